### src/imm_pkg.sv
// Shared constants, codes and types for the integer matrix multiply block.
// Standalone package; used by imm_store, imm_mac and integer_matrix_multiply.
`default_nettype none

package imm_pkg;

	// Matrix geometry
	localparam int MAX_DIM  = 16;
	localparam int ELEM_W   = 32;
	localparam int ACC_W    = 64;
	localparam int PROD_W   = 2 * ELEM_W;
	localparam int DEPTH    = MAX_DIM * MAX_DIM;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LIM_W    = 2 * DIM_W;

	// Port field widths
	localparam int OP_W      = 2;
	localparam int IN_DATA_W = 32;
	localparam int POS_W     = 4;
	localparam int OUT_W     = ACC_W + 2 * POS_W;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	// Item opcodes
	localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OP_W-1:0] OP_EMIT   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

	// Control that travels with each operand pair into the MAC
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

	// Register value to working dimension: zero acts as one, large values clamp
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### src/imm_store.sv
// Element stores for matrices A and B: one write and one registered read each.
// Depends on imm_pkg for depth and element width.
`default_nettype none

module imm_store import imm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              we_a,
	input  wire logic              we_b,
	input  wire logic [ADDR_W-1:0] waddr_a,
	input  wire logic [ADDR_W-1:0] waddr_b,
	input  wire logic [ELEM_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output      logic [ELEM_W-1:0] rdata_a,
	output      logic [ELEM_W-1:0] rdata_b
);

	logic [ELEM_W-1:0] mem_a [DEPTH];
	logic [ELEM_W-1:0] mem_b [DEPTH];

	// A store
	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr_a] <= wdata;
		end
		rdata_a <= mem_a[raddr_a];
	end

	// B store
	always_ff @(posedge clk) begin
		if (we_b) begin
			mem_b[waddr_b] <= wdata;
		end
		rdata_b <= mem_b[raddr_b];
	end

endmodule

`default_nettype wire

### src/imm_mac.sv
// Shared multiply-accumulate unit: registered signed multiply, then 64-bit add.
// Depends on imm_pkg for widths and the mac_ctl_t control struct.
`default_nettype none

module imm_mac import imm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mac_ctl_t          ctl,
	input  wire logic [ELEM_W-1:0] a,
	input  wire logic [ELEM_W-1:0] b,
	output      logic [ACC_W-1:0]  acc,
	output      logic              done
);

	mac_ctl_t           ctl_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0]   acc_q;
	logic               done_q;

	// Stage 1: product, operands sign-extended to the full product width
	always_ff @(posedge clk) begin
		prod_s1 <= $signed(a) * $signed(b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_q <= ctl_s1.vld & ctl_s1.last;
		end
	end

	// Stage 2: accumulate, restart on the first term; wraps mod 2^64
	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			if (ctl_s1.first) begin
				acc_q <= ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

### src/integer_matrix_multiply.sv
// Channel  Dir  Handshake               Payload
// s_       in   s_tvalid / s_tready     s_tuser opcode, s_tdata element_value
// m_       out  m_tvalid / m_tready     m_tdata product,row,col; m_tlast is_last
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// For an emit beat the sequencer streams one A/B pair per cycle through the
// single MAC; the sum then passes the store read, multiply and add registers
// and is moved into the output register. s_tready is low while a product
// is being formed; a held output beat stalls the finish. Reset clears
// dimensions to 1 and all pointers; stores are not cleared. cfg_ready is
// high only while idle with no input beat offered.
// Top level: sequencer, pointers and output register; uses imm_store, imm_mac.
`default_nettype none

module integer_matrix_multiply import imm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// slave stream
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,   // [31:0] element_value
	input  wire logic [OP_W-1:0]      s_tuser,   // [1:0] opcode
	// master stream
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [OUT_W-1:0]     m_tdata,   // [63:0] product_value, [67:64] out_row,
	                                             // [71:68] out_col
	output      logic                 m_tlast,   // is_last
	// configuration writes
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0]        state_q;
	logic [CFG_W-1:0]  rows_q, inner_q, cols_q;
	logic [DIM_W-1:0]  nr, nk, nc;
	logic [LIM_W-1:0]  lim_a, lim_b, ptr_a_nxt, ptr_b_nxt;
	logic [ADDR_W-1:0] load_ptr_a_q, load_ptr_b_q;
	logic [IDX_W-1:0]  emit_row_q, emit_col_q;
	logic [ADDR_W-1:0] row_base_q, b_ptr_q, a_raddr;
	logic [DIM_W-1:0]  k_q;
	logic              k_last;
	mac_ctl_t          rd_ctl_s1;
	logic [ELEM_W-1:0] rd_a, rd_b;
	logic [ACC_W-1:0]  acc;
	logic              mac_done;
	logic              in_acc, cfg_acc, cfg_hit, out_free, out_load;
	logic              row_end, col_end;
	logic              m_tvalid_q, m_tlast_q;
	logic [OUT_W-1:0]  m_tdata_q;

	// Working dimensions and load limits
	assign nr    = eff_dim(rows_q);
	assign nk    = eff_dim(inner_q);
	assign nc    = eff_dim(cols_q);
	assign lim_a = LIM_W'(nr) * LIM_W'(nk);
	assign lim_b = LIM_W'(nk) * LIM_W'(nc);

	// Register writes only while idle; an offered input beat goes first
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) & ~s_tvalid;
	assign in_acc    = s_tvalid & s_tready;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign cfg_hit   = cfg_acc & ((cfg_index == CFG_ROWS_A) || (cfg_index == CFG_INNER_DIM)
	                   || (cfg_index == CFG_COLS_B));

	assign ptr_a_nxt = LIM_W'(load_ptr_a_q) + LIM_W'(1);
	assign ptr_b_nxt = LIM_W'(load_ptr_b_q) + LIM_W'(1);

	assign out_free = ~m_tvalid_q | m_tready;
	assign out_load = (state_q == S_WAIT) & out_free;
	assign row_end  = (DIM_W'(emit_row_q) == nr - DIM_W'(1));
	assign col_end  = (DIM_W'(emit_col_q) == nc - DIM_W'(1));
	assign k_last   = (k_q == nk - DIM_W'(1));
	assign a_raddr  = ADDR_W'(LIM_W'(row_base_q) + LIM_W'(k_q));

	// Dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_W'(1);
			inner_q <= CFG_W'(1);
			cols_q  <= CFG_W'(1);
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_ROWS_A:    rows_q  <= cfg_data;
				CFG_INNER_DIM: inner_q <= cfg_data;
				CFG_COLS_B:    cols_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Load pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_a_q <= '0;
			load_ptr_b_q <= '0;
		end else if (cfg_hit) begin
			load_ptr_a_q <= '0;
			load_ptr_b_q <= '0;
		end else if (in_acc) begin
			if (s_tuser == OP_LOAD_A) begin
				load_ptr_a_q <= (ptr_a_nxt == lim_a) ? '0 : ADDR_W'(ptr_a_nxt);
			end
			if (s_tuser == OP_LOAD_B) begin
				load_ptr_b_q <= (ptr_b_nxt == lim_b) ? '0 : ADDR_W'(ptr_b_nxt);
			end
		end
	end

	// Emit position; row_base_q tracks emit_row_q * inner_dim
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_row_q <= '0;
			emit_col_q <= '0;
			row_base_q <= '0;
		end else if (cfg_hit) begin
			emit_row_q <= '0;
			emit_col_q <= '0;
			row_base_q <= '0;
		end else if (out_load) begin
			if (col_end) begin
				emit_col_q <= '0;
				if (row_end) begin
					emit_row_q <= '0;
					row_base_q <= '0;
				end else begin
					emit_row_q <= emit_row_q + IDX_W'(1);
					row_base_q <= ADDR_W'(LIM_W'(row_base_q) + LIM_W'(nk));
				end
			end else begin
				emit_col_q <= emit_col_q + IDX_W'(1);
			end
		end
	end

	// Sequencer: issue one A/B pair per cycle, drain the MAC, then hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			k_q       <= '0;
			b_ptr_q   <= '0;
			rd_ctl_s1 <= '0;
		end else begin
			rd_ctl_s1 <= '0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && s_tuser == OP_EMIT) begin
						k_q     <= '0;
						b_ptr_q <= ADDR_W'(emit_col_q);
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					rd_ctl_s1.vld   <= 1'b1;
					rd_ctl_s1.first <= (k_q == '0);
					rd_ctl_s1.last  <= k_last;
					k_q     <= k_q + DIM_W'(1);
					b_ptr_q <= ADDR_W'(LIM_W'(b_ptr_q) + LIM_W'(nc));
					if (k_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (mac_done) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	imm_store u_store (
		.clk     (clk),
		.we_a    (in_acc && s_tuser == OP_LOAD_A),
		.we_b    (in_acc && s_tuser == OP_LOAD_B),
		.waddr_a (load_ptr_a_q),
		.waddr_b (load_ptr_b_q),
		.wdata   (s_tdata[ELEM_W-1:0]),
		.raddr_a (a_raddr),
		.raddr_b (b_ptr_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	imm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rd_ctl_s1),
		.a      (rd_a),
		.b      (rd_b),
		.acc    (acc),
		.done   (mac_done)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {POS_W'(emit_col_q), POS_W'(emit_row_q), acc};
			m_tlast_q <= row_end & col_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTHESIS
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("output beat overwritten");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(DIM_W'(emit_row_q) < nr) && (DIM_W'(emit_col_q) < nc))
		else $error("emit position outside product");
	a_ptr_a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(LIM_W'(load_ptr_a_q) < lim_a) && (LIM_W'(load_ptr_b_q) < lim_b))
		else $error("load pointer past matrix size");
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == S_DRAIN))
		else $error("MAC finished outside drain");
`endif

endmodule

`default_nettype wire
